>>> sv/lmfb_pkg.sv
package lmfb_pkg;

    // Matrix geometry
    localparam int ROWS  = 8;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COLS  = 8;
    localparam int COL_W = $clog2(COLS);

    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [7:0]       ROW_LIMIT = 8'(ROWS);
    localparam logic [7:0]       MAX_COL   = 8'(COLS - 1);

    localparam logic [7:0] ALL_OFF = 8'hFF;
    localparam logic [7:0] TOP_BIT = 8'h80;
    localparam logic [7:0] LAST_SEL = TOP_BIT >> (ROWS - 1);

    // Command codes
    localparam logic [2:0] CMD_SET       = 3'd0;
    localparam logic [2:0] CMD_RD_PEND   = 3'd1;
    localparam logic [2:0] CMD_RD_SHOWN  = 3'd2;
    localparam logic [2:0] CMD_CLEAR     = 3'd3;
    localparam logic [2:0] CMD_DRAW      = 3'd4;

    // Result kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // Row store access for one cycle
    typedef struct packed {
        logic             pend_we;
        logic             shown_we;
        logic             rd_shown;
        logic [ROW_W-1:0] idx;
    } store_ctl_t;

endpackage

>>> sv/lmfb_row_store.sv
module lmfb_row_store (
    input  logic                aclk,
    input  logic                aresetn,
    input  lmfb_pkg::store_ctl_t ctl,
    input  logic [7:0]          pend_wdata,
    output logic [7:0]          rd_data
);
    import lmfb_pkg::*;

    logic [7:0] pend_reg  [ROWS];
    logic [7:0] shown_reg [ROWS];

    // Shown rows load straight from the pending row at the same index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ROWS; i++) begin
                pend_reg[i]  <= ALL_OFF;
                shown_reg[i] <= ALL_OFF;
            end
        end else begin
            if (ctl.pend_we) begin
                pend_reg[ctl.idx] <= pend_wdata;
            end
            if (ctl.shown_we) begin
                shown_reg[ctl.idx] <= pend_reg[ctl.idx];
            end
        end
    end

    assign rd_data = ctl.rd_shown ? shown_reg[ctl.idx] : pend_reg[ctl.idx];

endmodule

>>> sv/lmfb_pixel_unit.sv
module lmfb_pixel_unit (
    input  logic [7:0]                  row_byte,
    input  logic [lmfb_pkg::COL_W-1:0]  col,
    input  logic                        lit,
    output logic [7:0]                  new_byte,
    output logic                        pixel_on
);
    import lmfb_pkg::*;

    logic [7:0] mask;

    // Column 0 sits in the MSB; a low bit means lit
    assign mask     = TOP_BIT >> col;
    assign new_byte = lit ? (row_byte & ~mask) : (row_byte | mask);
    assign pixel_on = ~|(row_byte & mask);

endmodule

>>> sv/lmfb_seq.sv
module lmfb_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_cmd,
    input  logic [7:0]           s_row,
    input  logic [7:0]           s_col,
    input  logic                 s_lit,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_kind,
    output logic                 m_pixel_on,
    output logic [7:0]           m_row_select,
    output logic [7:0]           m_row_pixels,
    output logic                 m_last,
    output lmfb_pkg::store_ctl_t ctl,
    output logic [7:0]           pend_wdata,
    input  logic [7:0]           rd_data
);
    import lmfb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_SWEEP = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [2:0]       cmd_reg;
    logic [7:0]       row_reg, col_reg;
    logic             lit_reg;
    logic [ROW_W-1:0] idx_reg, idx_next;

    logic             out_valid_reg, out_valid_next;
    logic             out_kind_reg, out_kind_next;
    logic             out_on_reg, out_on_next;
    logic [7:0]       out_sel_reg, out_sel_next;
    logic [7:0]       out_pix_reg, out_pix_next;
    logic             out_last_reg, out_last_next;

    logic             accept;
    logic             slot_free;
    logic             coords_ok;
    logic [7:0]       unit_byte;
    logic             unit_on;

    lmfb_pixel_unit u_unit (
        .row_byte (rd_data),
        .col      (col_reg[COL_W-1:0]),
        .lit      (lit_reg),
        .new_byte (unit_byte),
        .pixel_on (unit_on)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !out_valid_reg || m_ready;
    assign coords_ok = (row_reg < ROW_LIMIT) && (col_reg <= MAX_COL);

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_kind_next  = out_kind_reg;
        out_on_next    = out_on_reg;
        out_sel_next   = out_sel_reg;
        out_pix_next   = out_pix_reg;
        out_last_next  = out_last_reg;
        ctl.pend_we    = 1'b0;
        ctl.shown_we   = 1'b0;
        ctl.rd_shown   = 1'b0;
        ctl.idx        = idx_reg;
        pend_wdata     = ALL_OFF;

        unique case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                if (accept) begin
                    unique case (s_cmd)
                        CMD_SET, CMD_RD_PEND, CMD_RD_SHOWN: state_next = ST_EXEC;
                        CMD_CLEAR, CMD_DRAW:                state_next = ST_SWEEP;
                        default:                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EXEC: begin
                ctl.idx      = row_reg[ROW_W-1:0];
                ctl.rd_shown = (cmd_reg == CMD_RD_SHOWN);
                pend_wdata   = unit_byte;
                if (cmd_reg == CMD_SET) begin
                    ctl.pend_we = coords_ok;
                    state_next  = ST_IDLE;
                end else if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_PIXEL;
                    out_on_next    = coords_ok && unit_on;
                    out_sel_next   = '0;
                    out_pix_next   = '0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                if (cmd_reg == CMD_CLEAR) begin
                    ctl.pend_we = 1'b1;
                    idx_next    = idx_reg + 1'b1;
                    if (idx_reg == LAST_ROW) begin
                        state_next = ST_IDLE;
                    end
                end else if (slot_free) begin
                    ctl.shown_we   = 1'b1;
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_FRAME;
                    out_on_next    = 1'b0;
                    out_sel_next   = TOP_BIT >> idx_reg;
                    out_pix_next   = rd_data;
                    out_last_next  = (idx_reg == LAST_ROW);
                    idx_next       = idx_reg + 1'b1;
                    if (idx_reg == LAST_ROW) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_cmd;
            row_reg <= s_row;
            col_reg <= s_col;
            lit_reg <= s_lit;
        end
        out_kind_reg <= out_kind_next;
        out_on_reg   <= out_on_next;
        out_sel_reg  <= out_sel_next;
        out_pix_reg  <= out_pix_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_kind       = out_kind_reg;
    assign m_pixel_on   = out_on_reg;
    assign m_row_select = out_sel_reg;
    assign m_row_pixels = out_pix_reg;
    assign m_last       = out_last_reg;

endmodule

>>> sv/led_matrix_frame_buffer.sv
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_cmd[2:0] s_row[7:0] s_col[7:0] s_lit
// m_        out        m_valid / m_ready    m_kind m_pixel_on m_row_select[7:0]
//                                           m_row_pixels[7:0] m_last
//
// Set and read commands are accepted, then make one row access through the
// pixel unit; clear and draw sweep one row per cycle unless a draw row waits.
// Unused command codes are dropped in the accept cycle.
// The pace is set by the single row access port of the store and the one output
// register: a read or draw row waits while the previous transfer is still held.
// aresetn (synchronous, active low) sets both buffers to all off and empties the
// output register; s_ready is high only in the idle state.
module led_matrix_frame_buffer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_cmd,
    input  logic [7:0] s_row,
    input  logic [7:0] s_col,
    input  logic       s_lit,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic       m_pixel_on,
    output logic [7:0] m_row_select,
    output logic [7:0] m_row_pixels,
    output logic       m_last
);
    import lmfb_pkg::*;

    // Row access issued by the sequencer each cycle
    store_ctl_t ctl;
    logic [7:0] pend_wdata;
    logic [7:0] rd_data;

    // Sequencer: capture the command, step rows, hold results for transfer
    lmfb_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_row        (s_row),
        .s_col        (s_col),
        .s_lit        (s_lit),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_pixel_on   (m_pixel_on),
        .m_row_select (m_row_select),
        .m_row_pixels (m_row_pixels),
        .m_last       (m_last),
        .ctl          (ctl),
        .pend_wdata   (pend_wdata),
        .rd_data      (rd_data)
    );

    // Pending and displayed row buffers
    lmfb_row_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .pend_wdata (pend_wdata),
        .rd_data    (rd_data)
    );

endmodule

>>> sv/lmfb_checker.sv
module lmfb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [2:0] s_cmd,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_kind,
    input logic       m_pixel_on,
    input logic [7:0] m_row_select,
    input logic [7:0] m_row_pixels,
    input logic       m_last
);
    import lmfb_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_pixel_on)
            && $stable(m_row_select) && $stable(m_row_pixels) && $stable(m_last))
        else $error("result changed while stalled");

    a_read_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_PIXEL) |->
            m_last && (m_row_select == 8'h00) && (m_row_pixels == 8'h00))
        else $error("read answer malformed");

    a_frame_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_FRAME) |-> $onehot(m_row_select) && !m_pixel_on
            && (m_last == (m_row_select == LAST_SEL)))
        else $error("draw frame malformed");

    a_busy_after_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_cmd == CMD_SET || s_cmd == CMD_RD_PEND
            || s_cmd == CMD_RD_SHOWN || s_cmd == CMD_CLEAR || s_cmd == CMD_DRAW)
            |=> !s_ready)
        else $error("input ready right after a command transfer");

endmodule

bind led_matrix_frame_buffer lmfb_checker u_lmfb_checker (.*);

>>> verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lmfb_pkg::*;

    // Command codes that the block ignores
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    localparam int STALL_CYCLES = 400;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int REPORT_MAX   = 10;

    // One result transfer on the m_ channel
    typedef struct packed {
        logic       kind;
        logic       pixel_on;
        logic [7:0] row_select;
        logic [7:0] row_pixels;
        logic       last;
    } frame_t;

    // One row of the directed table; typed rows carry their read answer
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] row;
        logic [7:0] col;
        logic       lit;
        logic       typed;
        logic       typed_on;
    } stim_row_t;

    localparam int DIR_N = 25;

    // Directed stimulus: reset state, corners, bad coordinates, clear leaving the
    // displayed buffer alone, ignored codes and draws copying pending to displayed.
    localparam stim_row_t DIR_TBL [DIR_N] = '{
        '{CMD_RD_PEND,  8'd0,   8'd0,   1'b0, 1'b1, 1'b0},
        '{CMD_RD_SHOWN, 8'd7,   8'd7,   1'b0, 1'b1, 1'b0},
        '{CMD_SET,      8'd0,   8'd0,   1'b1, 1'b0, 1'b0},
        '{CMD_SET,      8'd7,   8'd7,   1'b1, 1'b0, 1'b0},
        '{CMD_SET,      8'd3,   8'd5,   1'b1, 1'b0, 1'b0},
        '{CMD_RD_PEND,  8'd0,   8'd0,   1'b0, 1'b1, 1'b1},
        '{CMD_RD_SHOWN, 8'd0,   8'd0,   1'b0, 1'b1, 1'b0},
        '{CMD_DRAW,     8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
        '{CMD_RD_SHOWN, 8'd7,   8'd7,   1'b0, 1'b1, 1'b1},
        '{CMD_SET,      8'd8,   8'd0,   1'b1, 1'b0, 1'b0},
        '{CMD_SET,      8'd0,   8'd8,   1'b1, 1'b0, 1'b0},
        '{CMD_SET,      8'd255, 8'd255, 1'b1, 1'b0, 1'b0},
        '{CMD_RD_PEND,  8'd8,   8'd0,   1'b0, 1'b1, 1'b0},
        '{CMD_RD_PEND,  8'd0,   8'd255, 1'b0, 1'b1, 1'b0},
        '{CMD_RD_SHOWN, 8'd255, 8'd255, 1'b1, 1'b1, 1'b0},
        '{CMD_SET,      8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
        '{CMD_RD_PEND,  8'd0,   8'd0,   1'b0, 1'b1, 1'b0},
        '{CMD_CLEAR,    8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
        '{CMD_RD_SHOWN, 8'd7,   8'd7,   1'b0, 1'b1, 1'b1},
        '{CMD_RD_PEND,  8'd7,   8'd7,   1'b0, 1'b1, 1'b0},
        '{CMD_SPARE_A,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
        '{CMD_SPARE_B,  8'd170, 8'd85,  1'b1, 1'b0, 1'b0},
        '{CMD_SPARE_C,  8'd255, 8'd255, 1'b1, 1'b0, 1'b0},
        '{CMD_DRAW,     8'd255, 8'd255, 1'b1, 1'b0, 1'b0},
        '{CMD_RD_SHOWN, 8'd3,   8'd5,   1'b0, 1'b1, 1'b0}
    };

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [2:0] s_cmd;
    logic [7:0] s_row;
    logic [7:0] s_col;
    logic       s_lit;
    logic       m_valid;
    logic       m_ready;
    logic       m_kind;
    logic       m_pixel_on;
    logic [7:0] m_row_select;
    logic [7:0] m_row_pixels;
    logic       m_last;

    // Side information that travels with the item on the s_ channel
    logic cur_typed;
    logic cur_on;

    // Idle rates in percent, the long output hold-off and its trigger
    int   send_idle_pct;
    int   recv_idle_pct;
    logic m_hold;
    bit   stall_req;

    // Predicted image of both buffers and the results still to come
    logic [7:0] pend_img  [ROWS];
    logic [7:0] shown_img [ROWS];
    frame_t     frames_due [$];

    int fail_cnt;
    int accepted_cnt;
    int draw_cnt;
    int checked_cnt;

    led_matrix_frame_buffer uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_row        (s_row),
        .s_col        (s_col),
        .s_lit        (s_lit),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_pixel_on   (m_pixel_on),
        .m_row_select (m_row_select),
        .m_row_pixels (m_row_pixels),
        .m_last       (m_last)
    );

    // 12 ns clock
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Advance the buffer image by one accepted command and queue the frames it
    // causes; emit is low where the directed table supplies the answer itself.
    task automatic apply_command(input logic [2:0] cmd, input logic [7:0] row,
                                 input logic [7:0] col, input logic lit, input bit emit);
        frame_t     f;
        logic [7:0] mask;
        logic [7:0] src;
        bit         ok;
        ok   = (row < ROW_LIMIT) && (col <= MAX_COL);
        mask = TOP_BIT >> col[2:0];
        case (cmd)
            CMD_SET: begin
                if (ok) begin
                    // active low: clear the bit to light the pixel
                    if (lit)
                        pend_img[row] = pend_img[row] & ~mask;
                    else
                        pend_img[row] = pend_img[row] | mask;
                end
            end
            CMD_RD_PEND, CMD_RD_SHOWN: begin
                f      = '0;
                f.kind = KIND_PIXEL;
                f.last = 1'b1;
                if (ok) begin
                    src        = (cmd == CMD_RD_PEND) ? pend_img[row] : shown_img[row];
                    f.pixel_on = ((src & mask) == 8'h00);
                end
                if (emit)
                    frames_due.push_back(f);
            end
            CMD_CLEAR: begin
                // the displayed buffer holds until the next draw
                for (int r = 0; r < ROWS; r++)
                    pend_img[r] = ALL_OFF;
            end
            CMD_DRAW: begin
                for (int r = 0; r < ROWS; r++) begin
                    f            = '0;
                    f.kind       = KIND_FRAME;
                    f.row_select = TOP_BIT >> r;
                    f.row_pixels = pend_img[r];
                    f.last       = (r == ROWS - 1);
                    shown_img[r] = pend_img[r];
                    if (emit)
                        frames_due.push_back(f);
                end
            end
            default: begin
                // unused codes: drop
            end
        endcase
    endtask

    // Offer one item; called right after a falling edge and returns at one, with
    // s_valid still high so that the next item follows without a gap.
    task automatic send_item(input logic [2:0] cmd, input logic [7:0] row,
                             input logic [7:0] col, input logic lit,
                             input logic typed, input logic typed_on);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= cmd;
        s_row     <= row;
        s_col     <= col;
        s_lit     <= lit;
        cur_typed <= typed;
        cur_on    <= typed_on;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Random commands, mostly on the matrix, with a few far-off coordinates,
    // ignored codes, clears and draws mixed in.
    task automatic run_random(input int quota, input int s_pct, input int r_pct,
                              input bit squeeze);
        int         counted;
        int         pick;
        logic [2:0] cmd;
        logic [7:0] row;
        logic [7:0] col;
        logic       lit;
        counted       = 0;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        if (squeeze)
            stall_req = 1'b1;
        while (counted < quota) begin
            pick = $urandom_range(99);
            if (pick < 45)
                cmd = CMD_SET;
            else if (pick < 62)
                cmd = CMD_RD_PEND;
            else if (pick < 77)
                cmd = CMD_RD_SHOWN;
            else if (pick < 80)
                cmd = CMD_CLEAR;
            else if (pick < 88)
                cmd = CMD_DRAW;
            else if (pick < 92)
                cmd = 3'($urandom_range(CMD_SPARE_C, CMD_SPARE_A));
            else
                cmd = CMD_SET;
            row = ($urandom_range(99) < 88) ? 8'($urandom_range(ROWS - 1))
                                            : 8'($urandom_range(255));
            col = ($urandom_range(99) < 88) ? 8'($urandom_range(MAX_COL))
                                            : 8'($urandom_range(255));
            lit = 1'($urandom_range(1));
            send_item(cmd, row, col, lit, 1'b0, 1'b0);
            if (cmd <= CMD_DRAW)
                counted++;
        end
    endtask

    // Receiver: idle at the current rate, and hold off entirely during the stall
    always @(negedge aclk)
        m_ready <= !m_hold && ($urandom_range(99) >= recv_idle_pct);

    // Long output hold-off: count the cycles here while the sender keeps offering
    initial begin
        int hold_n;
        m_hold = 1'b0;
        wait (stall_req);
        @(negedge aclk);
        m_hold <= 1'b1;
        for (hold_n = 0; hold_n < STALL_CYCLES; hold_n++)
            @(negedge aclk);
        m_hold <= 1'b0;
    end

    // Monitor: check each result transfer against the oldest prediction, then
    // predict from any command accepted at the same edge.
    always @(posedge aclk) begin : monitor
        frame_t got;
        frame_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_kind, m_pixel_on, m_row_select, m_row_pixels, m_last};
                if (frames_due.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX)
                        $display("%0t: unexpected result kind=%0b on=%0b sel=%h pix=%h last=%0b",
                                 $realtime, got.kind, got.pixel_on, got.row_select,
                                 got.row_pixels, got.last);
                end else begin
                    want = frames_due.pop_front();
                    checked_cnt++;
                    if (got !== want) begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_MAX)
                            $display({"%0t: mismatch exp kind=%0b on=%0b sel=%h pix=%h last=%0b",
                                      " got kind=%0b on=%0b sel=%h pix=%h last=%0b"},
                                     $realtime, want.kind, want.pixel_on, want.row_select,
                                     want.row_pixels, want.last, got.kind, got.pixel_on,
                                     got.row_select, got.row_pixels, got.last);
                    end
                end
            end
            if (s_valid && s_ready) begin
                accepted_cnt++;
                if (s_cmd == CMD_DRAW)
                    draw_cnt++;
                apply_command(s_cmd, s_row, s_col, s_lit, !cur_typed);
                if (cur_typed) begin
                    want            = '0;
                    want.kind       = KIND_PIXEL;
                    want.pixel_on   = cur_on;
                    want.last       = 1'b1;
                    frames_due.push_back(want);
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int drain_n;
        s_valid       = 1'b0;
        s_cmd         = CMD_SET;
        s_row         = '0;
        s_col         = '0;
        s_lit         = 1'b0;
        cur_typed     = 1'b0;
        cur_on        = 1'b0;
        m_ready       = 1'b0;
        aresetn       = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_req     = 1'b0;
        fail_cnt      = 0;
        accepted_cnt  = 0;
        draw_cnt      = 0;
        checked_cnt   = 0;
        for (int r = 0; r < ROWS; r++) begin
            pend_img[r]  = ALL_OFF;
            shown_img[r] = ALL_OFF;
        end

        // hold reset, then release it on a falling edge
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part under the first idle mix
        send_idle_pct = 8;
        recv_idle_pct = 55;
        for (int i = 0; i < DIR_N; i++)
            send_item(DIR_TBL[i].cmd, DIR_TBL[i].row, DIR_TBL[i].col, DIR_TBL[i].lit,
                      DIR_TBL[i].typed, DIR_TBL[i].typed_on);

        // random part: sender rarely idle, then receiver rarely idle, then no
        // idling at all, opening with the long output stall
        run_random(140, 8, 55, 1'b0);
        run_random(140, 55, 8, 1'b0);
        run_random(150, 0, 0, 1'b1);
        s_valid <= 1'b0;

        // drain, then allow for a full draw sweep plus output latency
        drain_n = 0;
        while (frames_due.size() != 0 && drain_n < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_n++;
        end
        repeat (30) @(posedge aclk);
        if (frames_due.size() != 0) begin
            $display("%0d predicted results never arrived", frames_due.size());
            fail_cnt += frames_due.size();
        end

        $display("Covered %0d accepted commands, %0d of them draws; %0d results compared.",
                 accepted_cnt, draw_cnt, checked_cnt);
        $display("Ran three idle mixes and a %0d-cycle output stall with the input held off.",
                 STALL_CYCLES);
        if (fail_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d failures", fail_cnt);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #3_000_000;
        $display("Watchdog expired with %0d results outstanding", frames_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> led_matrix_frame_buffer.f
sv/lmfb_pkg.sv
sv/lmfb_row_store.sv
sv/lmfb_pixel_unit.sv
sv/lmfb_seq.sv
sv/led_matrix_frame_buffer.sv
sv/lmfb_checker.sv
verif/testbench.sv
